FILE: design/spq_pkg.sv
// shared types and constants of the sorted priority queue
// no dependencies; used by spq_ctrl, spq_datapath and sorted_priority_queue

package spq_pkg;

  // fixed widths of the request and result words
  localparam int DATA_WIDTH  = 32;
  localparam int LIMIT_WIDTH = 4;
  localparam int APB_WIDTH   = 32;
  localparam int ADDR_WIDTH  = 2;

  // register byte addresses on the configuration port
  localparam logic [ADDR_WIDTH-1:0] ADDR_CAPACITY_LIMIT = 2'd0;

  // request action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // reset value of the capacity limit register
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 4'd8;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } spq_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;   // capture the incoming request
    logic exec;   // perform the held request and load the result register
  } spq_cmd_t;

endpackage

FILE: design/spq_ctrl.sv
// controller of the sorted priority queue: request/result handshakes and sequencing
// depends on spq_pkg

module spq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output spq_pkg::spq_cmd_t cmd
);

  spq_pkg::spq_state_t state;
  spq_pkg::spq_state_t state_next;
  logic                out_free;
  logic                res_valid;
  logic                res_valid_next;

  // result register is free when empty or being taken this cycle
  assign out_free = !res_valid || !out_stall;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spq_pkg::S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      spq_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = spq_pkg::S_EXEC;
        end
      end
      spq_pkg::S_EXEC: begin
        if (out_free) begin
          state_next = spq_pkg::S_IDLE;
        end
      end
      default: state_next = spq_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.load = 1'b0;
    cmd.exec = 1'b0;
    in_stall = 1'b1;
    unique case (state)
      spq_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      spq_pkg::S_EXEC: begin
        cmd.exec = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // result valid flag: set on execution, cleared when taken
  always_comb begin
    res_valid_next = res_valid;
    if (cmd.exec) begin
      res_valid_next = 1'b1;
    end else if (res_valid && !out_stall) begin
      res_valid_next = 1'b0;
    end
  end

  assign out_valid = res_valid;

endmodule

FILE: design/spq_datapath.sv
// datapath of the sorted priority queue: request register, sorted cell chain, result register
// depends on spq_pkg

module spq_datapath #(
  parameter int DEPTH          = 8,
  parameter int PRIORITY_WIDTH = 8,
  parameter int CW             = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  spq_pkg::spq_cmd_t                    cmd,
  input  logic [spq_pkg::LIMIT_WIDTH-1:0]      capacity_limit,
  input  logic                                 action,
  input  logic signed [spq_pkg::DATA_WIDTH-1:0] item_data,
  input  logic [PRIORITY_WIDTH-1:0]            item_priority,
  output logic [1:0]                           status,
  output logic signed [spq_pkg::DATA_WIDTH-1:0] out_data,
  output logic [PRIORITY_WIDTH-1:0]            out_priority,
  output logic [CW-1:0]                        occupancy
);

  localparam int MW = (CW > spq_pkg::LIMIT_WIDTH) ? CW : spq_pkg::LIMIT_WIDTH;

  // held request
  logic                           req_action;
  logic [spq_pkg::DATA_WIDTH-1:0] req_data;
  logic [PRIORITY_WIDTH-1:0]      req_priority;

  // cell chain, kept in serving order
  logic [spq_pkg::DATA_WIDTH-1:0] slot_data [DEPTH];
  logic [PRIORITY_WIDTH-1:0]      slot_priority [DEPTH];
  logic [spq_pkg::DATA_WIDTH-1:0] slot_data_next [DEPTH];
  logic [PRIORITY_WIDTH-1:0]      slot_priority_next [DEPTH];
  logic [DEPTH-1:0]               gt;
  logic [CW-1:0]                  held_count;
  logic [CW-1:0]                  held_count_next;

  // result register
  spq_pkg::status_t               res_status;
  spq_pkg::status_t               res_status_next;
  logic [spq_pkg::DATA_WIDTH-1:0] res_data;
  logic [spq_pkg::DATA_WIDTH-1:0] res_data_next;
  logic [PRIORITY_WIDTH-1:0]      res_priority;
  logic [PRIORITY_WIDTH-1:0]      res_priority_next;
  logic [CW-1:0]                  res_occupancy;

  logic is_full;
  logic is_empty;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_action   <= action;
      req_data     <= item_data;
      req_priority <= item_priority;
    end
  end

  // refusal conditions
  assign is_full  = (MW'(held_count) >= MW'(capacity_limit)) || (held_count == CW'(DEPTH));
  assign is_empty = (held_count == '0);

  // each held cell compares its priority with the new one
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i] = (CW'(i) < held_count) && (slot_priority[i] > req_priority);
    end
  end

  // next cell contents and result
  always_comb begin
    held_count_next   = held_count;
    res_status_next   = spq_pkg::ST_DONE;
    res_data_next     = '0;
    res_priority_next = '0;
    for (int i = 0; i < DEPTH; i++) begin
      slot_data_next[i]     = slot_data[i];
      slot_priority_next[i] = slot_priority[i];
    end
    if (req_action == spq_pkg::ACT_INSERT) begin
      if (is_full) begin
        res_status_next = spq_pkg::ST_FULL;
      end else begin
        held_count_next = held_count + CW'(1);
        for (int i = 0; i < DEPTH; i++) begin
          if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
            // move back to make room
            slot_data_next[i]     = slot_data[(i > 0) ? i - 1 : 0];
            slot_priority_next[i] = slot_priority[(i > 0) ? i - 1 : 0];
          end else if (gt[i] || held_count == CW'(i)) begin
            // landing cell of the new entry
            slot_data_next[i]     = req_data;
            slot_priority_next[i] = req_priority;
          end
        end
      end
    end else begin
      if (is_empty) begin
        res_status_next = spq_pkg::ST_EMPTY;
      end else begin
        held_count_next   = held_count - CW'(1);
        res_data_next     = slot_data[0];
        res_priority_next = slot_priority[0];
        for (int i = 0; i < DEPTH - 1; i++) begin
          slot_data_next[i]     = slot_data[i + 1];
          slot_priority_next[i] = slot_priority[i + 1];
        end
      end
    end
  end

  // cell chain update
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        slot_data[i]     <= slot_data_next[i];
        slot_priority[i] <= slot_priority_next[i];
      end
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else if (cmd.exec) begin
      held_count <= held_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status    <= res_status_next;
      res_data      <= res_data_next;
      res_priority  <= res_priority_next;
      res_occupancy <= held_count_next;
    end
  end

  assign status       = res_status;
  assign out_data     = res_data;
  assign out_priority = res_priority;
  assign occupancy    = res_occupancy;

endmodule

FILE: design/sorted_priority_queue.sv
// top level of the sorted priority queue: configuration port, controller and datapath
// depends on spq_pkg, spq_ctrl and spq_datapath
//
//   channel   handshake                 payload
//   request   in_valid / in_stall       action, item_data, item_priority
//   result    out_valid / out_stall     status, out_data, out_priority, occupancy
//   config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// a request is captured first, then makes one pass through the cell chain,
// where every cell compares and shifts at once.
// the next request is taken while a result still waits in the result register.
// a stalled result holds the chain pass until the result register frees up.
// rst is synchronous; it empties the queue and sets the capacity limit to 8.

module sorted_priority_queue #(
  parameter int DEPTH          = 8,
  parameter int PRIORITY_WIDTH = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  action,
  input  logic signed [spq_pkg::DATA_WIDTH-1:0] item_data,
  input  logic [PRIORITY_WIDTH-1:0]             item_priority,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [1:0]                            status,
  output logic signed [spq_pkg::DATA_WIDTH-1:0] out_data,
  output logic [PRIORITY_WIDTH-1:0]             out_priority,
  output logic [$clog2(DEPTH + 1)-1:0]          occupancy,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [spq_pkg::ADDR_WIDTH-1:0]        paddr,
  input  logic [spq_pkg::APB_WIDTH-1:0]         pwdata,
  output logic [spq_pkg::APB_WIDTH-1:0]         prdata,
  output logic                                  pready
);

  localparam int CW = $clog2(DEPTH + 1);

  spq_pkg::spq_cmd_t                 cmd;
  logic [spq_pkg::LIMIT_WIDTH-1:0]   capacity_limit;

  // configuration register: the only register sits at address 0
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= spq_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == spq_pkg::ADDR_CAPACITY_LIMIT) begin
      capacity_limit <= pwdata[spq_pkg::LIMIT_WIDTH-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = spq_pkg::APB_WIDTH'(capacity_limit);

  // controller
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // datapath
  spq_datapath #(
    .DEPTH          (DEPTH),
    .PRIORITY_WIDTH (PRIORITY_WIDTH),
    .CW             (CW)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .capacity_limit (capacity_limit),
    .action         (action),
    .item_data      (item_data),
    .item_priority  (item_priority),
    .status         (status),
    .out_data       (out_data),
    .out_priority   (out_priority),
    .occupancy      (occupancy)
  );

endmodule

FILE: tb/sorted_priority_queue_tb.sv
// self-checking testbench of the sorted priority queue
// depends on spq_pkg and sorted_priority_queue; keeps its own copy of the queue
`timescale 1ns / 1ps

module sorted_priority_queue_tb;

  localparam int DEPTH          = 8;
  localparam int PRIORITY_WIDTH = 8;
  localparam int CW             = $clog2(DEPTH + 1);
  localparam int QUIET_LIMIT    = 4000;
  localparam int PRINT_LIMIT    = 60;

  typedef struct {
    spq_pkg::status_t                   status;
    logic [spq_pkg::DATA_WIDTH-1:0]     data;
    logic [PRIORITY_WIDTH-1:0]          prio;
    logic [CW-1:0]                      occupancy;
  } queue_result_t;

  logic                                  clk = 1'b0;
  logic                                  rst = 1'b1;
  logic                                  in_valid = 1'b0;
  logic                                  in_stall;
  logic                                  action = spq_pkg::ACT_INSERT;
  logic signed [spq_pkg::DATA_WIDTH-1:0] item_data = '0;
  logic [PRIORITY_WIDTH-1:0]             item_priority = '0;
  logic                                  out_valid;
  logic                                  out_stall = 1'b0;
  logic [1:0]                            status;
  logic signed [spq_pkg::DATA_WIDTH-1:0] out_data;
  logic [PRIORITY_WIDTH-1:0]             out_priority;
  logic [CW-1:0]                         occupancy;
  logic                                  psel = 1'b0;
  logic                                  penable = 1'b0;
  logic                                  pwrite = 1'b0;
  logic [spq_pkg::ADDR_WIDTH-1:0]        paddr = '0;
  logic [spq_pkg::APB_WIDTH-1:0]         pwdata = '0;
  logic [spq_pkg::APB_WIDTH-1:0]         prdata;
  logic                                  pready;

  // mirror of the queue contents and the capacity register
  logic [spq_pkg::DATA_WIDTH-1:0]  held_data [DEPTH];
  logic [PRIORITY_WIDTH-1:0]       held_prio [DEPTH];
  int                              held_count = 0;
  logic [spq_pkg::LIMIT_WIDTH-1:0] capacity_limit = spq_pkg::LIMIT_RESET;

  queue_result_t pending_results[$];
  int            mismatch_count = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            hold_off_cycles = 0;
  int            quiet_cycles = 0;

  sorted_priority_queue dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .item_data     (item_data),
    .item_priority (item_priority),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .out_data      (out_data),
    .out_priority  (out_priority),
    .occupancy     (occupancy),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock, 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // one line per mismatch, printing capped
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // expected outcome of one request, updating the mirrored queue
  function automatic queue_result_t predict_queue_result(input logic act,
      input logic [spq_pkg::DATA_WIDTH-1:0] data, input logic [PRIORITY_WIDTH-1:0] prio);
    queue_result_t res;
    int            room;
    int            pos;
    res.status = spq_pkg::ST_DONE;
    res.data   = '0;
    res.prio   = '0;
    room = (capacity_limit > DEPTH) ? DEPTH : int'(capacity_limit);
    if (act == spq_pkg::ACT_INSERT) begin
      if (held_count >= room) begin
        res.status = spq_pkg::ST_FULL;
      end else begin
        // new entry moves ahead of strictly larger priority values only
        pos = held_count;
        while (pos > 0 && held_prio[pos-1] > prio) begin
          held_data[pos] = held_data[pos-1];
          held_prio[pos] = held_prio[pos-1];
          pos--;
        end
        held_data[pos] = data;
        held_prio[pos] = prio;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        res.status = spq_pkg::ST_EMPTY;
      end else begin
        res.data = held_data[0];
        res.prio = held_prio[0];
        for (int i = 1; i < held_count; i++) begin
          held_data[i-1] = held_data[i];
          held_prio[i-1] = held_prio[i];
        end
        held_count--;
      end
    end
    res.occupancy = CW'(held_count);
    return res;
  endfunction

  // offer one request, with random idle cycles ahead of it
  task automatic send_request(input logic act, input logic [spq_pkg::DATA_WIDTH-1:0] data,
                              input logic [PRIORITY_WIDTH-1:0] prio);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    action        <= act;
    item_data     <= data;
    item_priority <= prio;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_queue_result(act, data, prio));
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write the capacity limit, then read it back
  task automatic program_capacity_limit(input logic [spq_pkg::LIMIT_WIDTH-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= spq_pkg::ADDR_CAPACITY_LIMIT;
    pwdata  <= spq_pkg::APB_WIDTH'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    capacity_limit = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    psel    <= 1'b1;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== spq_pkg::APB_WIDTH'(value))
      report_mismatch("capacity_limit readback", prdata, spq_pkg::APB_WIDTH'(value));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // priorities biased towards extremes and ties
  function automatic logic [PRIORITY_WIDTH-1:0] random_priority();
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? '1 : '0;
      1:       return PRIORITY_WIDTH'($urandom_range(3));
      default: return PRIORITY_WIDTH'($urandom);
    endcase
  endfunction

  // receiver: long hold-off when asked, random stalls otherwise
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_stall <= 1'b1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result checking against the oldest prediction
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", status, '0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (out_data !== want.data) report_mismatch("out_data", out_data, want.data);
        if (out_priority !== want.prio)
          report_mismatch("out_priority", out_priority, want.prio);
        if (occupancy !== want.occupancy)
          report_mismatch("occupancy", occupancy, want.occupancy);
      end
    end
  end

  // watchdog on cycles with no request or result taken and no configuration access
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL sorted_priority_queue");
      $finish;
    end
  end

  // extremes of data and priority, ties, full at depth, empty removes
  task automatic test_ordering_extremes();
    send_idle_pct = 0;
    recv_idle_pct = 30;
    send_request(spq_pkg::ACT_REMOVE, '0, '0);
    send_request(spq_pkg::ACT_INSERT, 32'h7fff_ffff, 8'hff);
    send_request(spq_pkg::ACT_INSERT, 32'h8000_0000, 8'h00);
    send_request(spq_pkg::ACT_INSERT, 32'h0000_0000, 8'd128);
    send_request(spq_pkg::ACT_INSERT, 32'h0000_0005, 8'd128);
    send_request(spq_pkg::ACT_INSERT, 32'hffff_ffff, 8'h00);
    send_request(spq_pkg::ACT_INSERT, 32'h0000_0001, 8'd7);
    send_request(spq_pkg::ACT_INSERT, 32'h0000_0002, 8'd254);
    send_request(spq_pkg::ACT_INSERT, 32'h0000_0003, 8'd1);
    send_request(spq_pkg::ACT_INSERT, 32'h1234_5678, 8'd3);
    repeat (DEPTH + 1) send_request(spq_pkg::ACT_REMOVE, '0, '0);
    wait_until_drained();
  endtask

  // zero limit, small limit, limit lowered below the held count
  task automatic test_capacity_limits();
    program_capacity_limit(4'd0);
    send_request(spq_pkg::ACT_INSERT, 32'hdead_beef, 8'd9);
    send_request(spq_pkg::ACT_REMOVE, '0, '0);
    wait_until_drained();
    program_capacity_limit(4'd2);
    repeat (3) send_request(spq_pkg::ACT_INSERT, $urandom, random_priority());
    wait_until_drained();
    program_capacity_limit(4'd1);
    send_request(spq_pkg::ACT_INSERT, $urandom, random_priority());
    send_request(spq_pkg::ACT_REMOVE, '0, '0);
    send_request(spq_pkg::ACT_INSERT, $urandom, random_priority());
    send_request(spq_pkg::ACT_REMOVE, '0, '0);
    send_request(spq_pkg::ACT_INSERT, $urandom, random_priority());
    wait_until_drained();
  endtask

  // bursts leaning to inserts or removes so the queue fills and empties
  task automatic test_random_traffic(input logic [spq_pkg::LIMIT_WIDTH-1:0] limit,
                                     input int count, input int send_pct,
                                     input int recv_pct);
    int   left;
    int   burst;
    int   insert_pct;
    logic act;
    program_capacity_limit(limit);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    left = count;
    while (left > 0) begin
      burst      = $urandom_range(12, 1);
      insert_pct = $urandom_range(1) ? 80 : 25;
      while (burst > 0 && left > 0) begin
        act = ($urandom_range(99) < insert_pct) ? spq_pkg::ACT_INSERT : spq_pkg::ACT_REMOVE;
        send_request(act, $urandom, random_priority());
        burst--;
        left--;
      end
    end
    wait_until_drained();
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_result_backpressure();
    program_capacity_limit(4'd8);
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    hold_off_cycles = 150;
    repeat (30)
      send_request($urandom_range(3) == 0 ? spq_pkg::ACT_REMOVE : spq_pkg::ACT_INSERT,
                   $urandom, random_priority());
    wait_until_drained();
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_ordering_extremes();
    test_capacity_limits();
    test_random_traffic(4'd8, 300, 25, 88);
    test_random_traffic(4'd5, 300, 88, 25);
    test_random_traffic(4'd15, 280, 0, 0);
    test_random_traffic(4'd2, 100, 0, 0);
    test_result_backpressure();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS sorted_priority_queue");
    end else begin
      $display("FAIL sorted_priority_queue");
    end
    $finish;
  end

endmodule
